@@ rtl/srlg_pkg.sv @@
package srlg_pkg;

   localparam int SUM_W      = 38;
   localparam int ROOT_W     = SUM_W / 2;
   localparam int DVSR_W     = 16;
   localparam int SMOOTH_W   = 32;
   localparam int ALPHA_W    = 16;
   localparam int FS_W       = 15;
   localparam int LEVEL_W    = 17;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 17;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam int STEP_W = 6;
   localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(SUM_W - 1);
   localparam logic [STEP_W-1:0] ROOT_LAST = STEP_W'(ROOT_W - 1);

   localparam logic [SUM_W-1:0]   SUM_LIMIT = '1;
   localparam logic [LEVEL_W-1:0] Q16_ONE   = 17'h10000;

   localparam logic [CSR_IDX_W-1:0] CSR_ALPHA      = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FULL_SCALE = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD  = 8'd2;

   localparam logic [ALPHA_W-1:0] ALPHA_RESET      = 16'd4588;
   localparam logic [FS_W-1:0]    FULL_SCALE_RESET = 15'd5571;
   localparam logic [LEVEL_W-1:0] THRESHOLD_RESET  = 17'd32768;

   typedef struct packed {
      logic [ALPHA_W-1:0] alpha;
      logic [FS_W-1:0]    full_scale;
      logic [LEVEL_W-1:0] threshold;
   } cfg_type;

   typedef struct packed {
      logic [SUM_W-1:0]  sum_left;
      logic [SUM_W-1:0]  sum_right;
      logic [DVSR_W-1:0] count;
   } buf_type;

   typedef struct packed {
      logic load;
      logic step;
   } unit_ctl_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MEAN,
      ST_ROOT_LD,
      ST_ROOT,
      ST_MUL,
      ST_SMOOTH,
      ST_SCALE_LD,
      ST_SCALE,
      ST_GATE,
      ST_OUT
   } back_state_type;

endpackage

@@ rtl/srlg_div.sv @@
module srlg_div (
   input  logic                         clock,
   input  srlg_pkg::unit_ctl_type       ctl,
   input  logic [srlg_pkg::SUM_W-1:0]   numer,
   input  logic [srlg_pkg::DVSR_W-1:0]  dvsr,
   output logic [srlg_pkg::SUM_W-1:0]   quot
);
   import srlg_pkg::*;

   logic [SUM_W-1:0]  num_ff, num_in;
   logic [DVSR_W-1:0] rem_ff, rem_in;
   logic [DVSR_W-1:0] dvsr_ff, dvsr_in;
   logic [DVSR_W:0]   trial;
   logic [DVSR_W:0]   diff;

   // restoring division, one quotient bit per step
   always_comb begin
      trial   = {rem_ff, num_ff[SUM_W-1]};
      diff    = trial - {1'b0, dvsr_ff};
      num_in  = num_ff;
      rem_in  = rem_ff;
      dvsr_in = dvsr_ff;
      if (ctl.load) begin
         num_in  = numer;
         rem_in  = '0;
         dvsr_in = dvsr;
      end else if (ctl.step) begin
         if (trial >= {1'b0, dvsr_ff}) begin
            rem_in = diff[DVSR_W-1:0];
            num_in = {num_ff[SUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DVSR_W-1:0];
            num_in = {num_ff[SUM_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff  <= num_in;
      rem_ff  <= rem_in;
      dvsr_ff <= dvsr_in;
   end

   assign quot = num_ff;

endmodule

@@ rtl/srlg_sqrt.sv @@
module srlg_sqrt (
   input  logic                        clock,
   input  srlg_pkg::unit_ctl_type      ctl,
   input  logic [srlg_pkg::SUM_W-1:0]  radicand,
   output logic [srlg_pkg::ROOT_W-1:0] root
);
   import srlg_pkg::*;

   logic [SUM_W-1:0]  x_ff, x_in;
   logic [ROOT_W:0]   rem_ff, rem_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [ROOT_W+2:0] shifted;
   logic [ROOT_W+2:0] trial;
   logic [ROOT_W+2:0] diff;

   // floor square root, one root bit per step
   always_comb begin
      shifted = {rem_ff, x_ff[SUM_W-1:SUM_W-2]};
      trial   = {1'b0, root_ff, 2'b01};
      diff    = shifted - trial;
      x_in    = x_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (ctl.load) begin
         x_in    = radicand;
         rem_in  = '0;
         root_in = '0;
      end else if (ctl.step) begin
         x_in = {x_ff[SUM_W-3:0], 2'b00};
         if (shifted >= trial) begin
            rem_in  = diff[ROOT_W:0];
            root_in = {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = shifted[ROOT_W:0];
            root_in = {root_ff[ROOT_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign root = root_ff;

endmodule

@@ rtl/srlg_front.sv @@
module srlg_front #(
   parameter int SAMPLE_BITS = 16,
   parameter int FRAMES_MAX  = 256
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic signed [SAMPLE_BITS-1:0] left_sample,
   input  logic signed [SAMPLE_BITS-1:0] right_sample,
   input  logic                          last_frame,
   output logic                          push,
   output srlg_pkg::buf_type             push_data
);
   import srlg_pkg::*;

   localparam int SQ_W  = 2 * SAMPLE_BITS;
   localparam int ADD_W = ((SQ_W > SUM_W) ? SQ_W : SUM_W) + 1;
   localparam int CNT_W = $clog2(FRAMES_MAX + 1);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRAMES_MAX);

   logic [SAMPLE_BITS-1:0] raw_l, raw_r;
   logic [SAMPLE_BITS-1:0] mag_l, mag_r;

   logic             s1_vld_ff;
   logic [SQ_W-1:0]  sq_l_ff, sq_r_ff;
   logic             last_ff;

   logic [SUM_W-1:0] sum_l_ff, sum_l_in;
   logic [SUM_W-1:0] sum_r_ff, sum_r_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   logic [ADD_W-1:0] add_l, add_r;
   logic [SUM_W-1:0] new_l, new_r;
   logic [CNT_W-1:0] cnt_new;
   logic             close;

   // squaring stage
   always_comb begin
      raw_l = $unsigned(left_sample);
      raw_r = $unsigned(right_sample);
      mag_l = raw_l[SAMPLE_BITS-1] ? (~raw_l + 1'b1) : raw_l;
      mag_r = raw_r[SAMPLE_BITS-1] ? (~raw_r + 1'b1) : raw_r;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         sq_l_ff <= mag_l * mag_l;
         sq_r_ff <= mag_r * mag_r;
         last_ff <= last_frame;
      end
   end

   // saturating accumulate and buffer close
   always_comb begin
      add_l   = ADD_W'(sum_l_ff) + ADD_W'(sq_l_ff);
      add_r   = ADD_W'(sum_r_ff) + ADD_W'(sq_r_ff);
      new_l   = (add_l > ADD_W'(SUM_LIMIT)) ? SUM_LIMIT : add_l[SUM_W-1:0];
      new_r   = (add_r > ADD_W'(SUM_LIMIT)) ? SUM_LIMIT : add_r[SUM_W-1:0];
      cnt_new = cnt_ff + 1'b1;
      close   = last_ff || (cnt_new == CNT_LAST);
      push    = s1_vld_ff && close;

      push_data.sum_left  = new_l;
      push_data.sum_right = new_r;
      push_data.count     = DVSR_W'(cnt_new);

      sum_l_in = sum_l_ff;
      sum_r_in = sum_r_ff;
      cnt_in   = cnt_ff;
      if (s1_vld_ff) begin
         if (close) begin
            sum_l_in = '0;
            sum_r_in = '0;
            cnt_in   = '0;
         end else begin
            sum_l_in = new_l;
            sum_r_in = new_r;
            cnt_in   = cnt_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_l_ff <= '0;
         sum_r_ff <= '0;
         cnt_ff   <= '0;
      end else begin
         sum_l_ff <= sum_l_in;
         sum_r_ff <= sum_r_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

@@ rtl/srlg_queue.sv @@
module srlg_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  srlg_pkg::buf_type push_data,
   input  logic              pop,
   output srlg_pkg::buf_type pop_data,
   output logic              empty,
   output logic              full,
   output logic              almost_full
);
   import srlg_pkg::*;

   buf_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   cnt_ff, cnt_in;

   always_comb begin
      wr_ptr_in = push ? (wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop ? (rd_ptr_ff + 1'b1) : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data    = entry_ff[rd_ptr_ff];
   assign empty       = (cnt_ff == '0);
   assign full        = (cnt_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign almost_full = (cnt_ff >= (QPTR_W+1)'(QUEUE_DEPTH - 1));

endmodule

@@ rtl/srlg_back.sv @@
module srlg_back (
   input  logic                         clock,
   input  logic                         reset,
   input  srlg_pkg::cfg_type            cfg,
   input  logic                         q_empty,
   input  srlg_pkg::buf_type            q_data,
   output logic                         q_pop,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [srlg_pkg::LEVEL_W-1:0] level_left,
   output logic [srlg_pkg::LEVEL_W-1:0] level_right,
   output logic                         gate_trigger,
   output logic                         gate_open
);
   import srlg_pkg::*;

   localparam int PO_W  = SMOOTH_W + LEVEL_W;
   localparam int PN_W  = ROOT_W + ALPHA_W;
   localparam int ACC_W = PN_W + ALPHA_W + 2;
   localparam logic [ACC_W-1:0] HALF = ACC_W'(32768);

   back_state_type state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;

   unit_ctl_type div_ctl, sqrt_ctl;
   logic mul_en, smooth_en, gate_en;

   logic [SUM_W-1:0]  div_numer_l, div_numer_r, quot_l, quot_r;
   logic [DVSR_W-1:0] div_dvsr;
   logic [FS_W-1:0]   fs_eff;
   logic [ROOT_W-1:0] root_l, root_r;

   logic [SMOOTH_W-1:0] smooth_l_ff, smooth_r_ff;
   logic                above_ff, above_in;
   logic                fire;
   logic [PO_W-1:0]     po_l_ff, po_r_ff;
   logic [PN_W-1:0]     pn_l_ff, pn_r_ff;
   logic [LEVEL_W-1:0]  keep;
   logic [ACC_W-1:0]    acc_l, acc_r;
   logic [SMOOTH_W-1:0] sat_l, sat_r;
   logic [LEVEL_W-1:0]  lvl_l, lvl_r;

   logic [LEVEL_W-1:0] level_l_ff, level_r_ff;
   logic               trig_ff, open_ff;

   // sequencer
   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      div_ctl   = '0;
      sqrt_ctl  = '0;
      q_pop     = 1'b0;
      mul_en    = 1'b0;
      smooth_en = 1'b0;
      gate_en   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop        = 1'b1;
               div_ctl.load = 1'b1;
               step_in      = '0;
               state_in     = ST_MEAN;
            end
         end
         ST_MEAN: begin
            div_ctl.step = 1'b1;
            step_in      = step_ff + 1'b1;
            if (step_ff == DIV_LAST) begin
               step_in  = '0;
               state_in = ST_ROOT_LD;
            end
         end
         ST_ROOT_LD: begin
            sqrt_ctl.load = 1'b1;
            state_in      = ST_ROOT;
         end
         ST_ROOT: begin
            sqrt_ctl.step = 1'b1;
            step_in       = step_ff + 1'b1;
            if (step_ff == ROOT_LAST) begin
               step_in  = '0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            mul_en   = 1'b1;
            state_in = ST_SMOOTH;
         end
         ST_SMOOTH: begin
            smooth_en = 1'b1;
            state_in  = ST_SCALE_LD;
         end
         ST_SCALE_LD: begin
            div_ctl.load = 1'b1;
            state_in     = ST_SCALE;
         end
         ST_SCALE: begin
            div_ctl.step = 1'b1;
            step_in      = step_ff + 1'b1;
            if (step_ff == DIV_LAST) begin
               step_in  = '0;
               state_in = ST_GATE;
            end
         end
         ST_GATE: begin
            gate_en  = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   // divider operands: mean square first, then level scaling
   always_comb begin
      fs_eff = (cfg.full_scale == '0) ? FS_W'(1) : cfg.full_scale;
      if (state_ff == ST_SCALE_LD) begin
         div_numer_l = SUM_W'(smooth_l_ff);
         div_numer_r = SUM_W'(smooth_r_ff);
         div_dvsr    = {fs_eff, 1'b0};
      end else begin
         div_numer_l = q_data.sum_left;
         div_numer_r = q_data.sum_right;
         div_dvsr    = q_data.count;
      end
   end

   srlg_div u_div_l (
      .clock (clock),
      .ctl   (div_ctl),
      .numer (div_numer_l),
      .dvsr  (div_dvsr),
      .quot  (quot_l)
   );

   srlg_div u_div_r (
      .clock (clock),
      .ctl   (div_ctl),
      .numer (div_numer_r),
      .dvsr  (div_dvsr),
      .quot  (quot_r)
   );

   srlg_sqrt u_sqrt_l (
      .clock    (clock),
      .ctl      (sqrt_ctl),
      .radicand (quot_l),
      .root     (root_l)
   );

   srlg_sqrt u_sqrt_r (
      .clock    (clock),
      .ctl      (sqrt_ctl),
      .radicand (quot_r),
      .root     (root_r)
   );

   // smoothing and gate
   always_comb begin
      keep  = Q16_ONE - LEVEL_W'(cfg.alpha);
      acc_l = ACC_W'(po_l_ff) + (ACC_W'(pn_l_ff) << ALPHA_W) + HALF;
      acc_r = ACC_W'(po_r_ff) + (ACC_W'(pn_r_ff) << ALPHA_W) + HALF;
      sat_l = (|acc_l[ACC_W-1:SMOOTH_W+ALPHA_W]) ? '1 : acc_l[SMOOTH_W+ALPHA_W-1:ALPHA_W];
      sat_r = (|acc_r[ACC_W-1:SMOOTH_W+ALPHA_W]) ? '1 : acc_r[SMOOTH_W+ALPHA_W-1:ALPHA_W];
      lvl_l = (quot_l > SUM_W'(Q16_ONE)) ? Q16_ONE : quot_l[LEVEL_W-1:0];
      lvl_r = (quot_r > SUM_W'(Q16_ONE)) ? Q16_ONE : quot_r[LEVEL_W-1:0];
      fire  = (lvl_l >= cfg.threshold) && !above_ff;
      above_in = lvl_l >= cfg.threshold;
   end

   always_ff @(posedge clock) begin
      if (mul_en) begin
         po_l_ff <= smooth_l_ff * keep;
         po_r_ff <= smooth_r_ff * keep;
         pn_l_ff <= root_l * cfg.alpha;
         pn_r_ff <= root_r * cfg.alpha;
      end
      if (gate_en) begin
         level_l_ff <= lvl_l;
         level_r_ff <= lvl_r;
         trig_ff    <= fire;
         open_ff    <= above_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         smooth_l_ff <= '0;
         smooth_r_ff <= '0;
         above_ff    <= 1'b0;
      end else begin
         if (smooth_en) begin
            smooth_l_ff <= sat_l;
            smooth_r_ff <= sat_r;
         end
         if (gate_en) begin
            above_ff <= above_in;
         end
      end
   end

   assign rsp_valid    = (state_ff == ST_OUT);
   assign level_left   = level_l_ff;
   assign level_right  = level_r_ff;
   assign gate_trigger = trig_ff;
   assign gate_open    = open_ff;

endmodule

@@ rtl/stereo_rms_level_gate_core.sv @@
// channel  direction  beat                                          handshake
// req      in         left_sample, right_sample, last_frame         req_valid / req_stall
// rsp      out        level_left, level_right, gate_trigger, open   rsp_valid / rsp_stall
// csr      in         csr_index, csr_data                           csr_valid / csr_ready
//
// frames are taken one per clock while the buffer queue is not nearly full
// per buffer the back end runs two 38-step bit-serial divides
// (mean square, level scaling) and a 19-step square root, then waits on rsp_stall
// reset is synchronous and clears sums, smoothed levels and gate state
// req_stall rises when the four-entry buffer queue is nearly full
module stereo_rms_level_gate_core #(
   parameter int SAMPLE_BITS = 16,
   parameter int FRAMES_MAX  = 256
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic signed [SAMPLE_BITS-1:0]   req_left_sample,
   input  logic signed [SAMPLE_BITS-1:0]   req_right_sample,
   input  logic                            req_last_frame,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [srlg_pkg::LEVEL_W-1:0]    rsp_level_left,
   output logic [srlg_pkg::LEVEL_W-1:0]    rsp_level_right,
   output logic                            rsp_gate_trigger,
   output logic                            rsp_gate_open,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [srlg_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [srlg_pkg::CSR_DATA_W-1:0] csr_data
);
   import srlg_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    req_accept;
   logic    q_push, q_pop, q_empty, q_full, q_almost_full;
   buf_type q_push_data, q_pop_data;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ALPHA:      cfg_in.alpha      = csr_data[ALPHA_W-1:0];
            CSR_FULL_SCALE: cfg_in.full_scale = csr_data[FS_W-1:0];
            CSR_THRESHOLD:  cfg_in.threshold  = csr_data[LEVEL_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.alpha      <= ALPHA_RESET;
         cfg_ff.full_scale <= FULL_SCALE_RESET;
         cfg_ff.threshold  <= THRESHOLD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_ready  = 1'b1;
   assign req_stall  = q_almost_full;
   assign req_accept = req_valid && !req_stall;

   srlg_front #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .FRAMES_MAX  (FRAMES_MAX)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (req_accept),
      .left_sample  (req_left_sample),
      .right_sample (req_right_sample),
      .last_frame   (req_last_frame),
      .push         (q_push),
      .push_data    (q_push_data)
   );

   srlg_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (q_push),
      .push_data   (q_push_data),
      .pop         (q_pop),
      .pop_data    (q_pop_data),
      .empty       (q_empty),
      .full        (q_full),
      .almost_full (q_almost_full)
   );

   srlg_back u_back (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .q_empty      (q_empty),
      .q_data       (q_pop_data),
      .q_pop        (q_pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .level_left   (rsp_level_left),
      .level_right  (rsp_level_right),
      .gate_trigger (rsp_gate_trigger),
      .gate_open    (rsp_gate_open)
   );

   a_no_push_when_full : assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("buffer queue overflow");

   a_no_pop_when_empty : assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("buffer queue underflow");

   a_trigger_opens_gate : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_gate_trigger) |-> rsp_gate_open)
      else $error("trigger without open gate");

   a_level_clamped : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_level_left <= Q16_ONE) && (rsp_level_right <= Q16_ONE))
      else $error("level above full scale");

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
   import srlg_pkg::*;

   localparam int SAMPLE_BITS   = 16;
   localparam int FRAMES_MAX    = 256;
   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int DRAIN_CYCLES  = 150;
   localparam int RANDOM_PHASES = 6;
   localparam int PHASE_FRAMES  = 72;

   typedef enum int {
      STALL_NONE,
      STALL_SPARSE,
      STALL_LONG
   } stall_mode_type;

   typedef struct {
      logic [LEVEL_W-1:0] level_left;
      logic [LEVEL_W-1:0] level_right;
      logic               gate_trigger;
      logic               gate_open;
   } level_beat_type;

   class level_tracker;
      logic [ALPHA_W-1:0] alpha;
      logic [FS_W-1:0]    full_scale;
      logic [LEVEL_W-1:0] threshold;
      longint unsigned    sum_left;
      longint unsigned    sum_right;
      longint unsigned    smooth_left;
      longint unsigned    smooth_right;
      int unsigned        frames;
      bit                 above;
      level_beat_type     levels_due[$];
      int                 errors;

      function new();
         alpha        = ALPHA_RESET;
         full_scale   = FULL_SCALE_RESET;
         threshold    = THRESHOLD_RESET;
         sum_left     = 0;
         sum_right    = 0;
         smooth_left  = 0;
         smooth_right = 0;
         frames       = 0;
         above        = 0;
         errors       = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         if (idx == CSR_ALPHA) begin
            alpha = data[ALPHA_W-1:0];
         end else if (idx == CSR_FULL_SCALE) begin
            full_scale = data[FS_W-1:0];
         end else if (idx == CSR_THRESHOLD) begin
            threshold = data[LEVEL_W-1:0];
         end
      endfunction

      function longint unsigned square(logic signed [SAMPLE_BITS-1:0] s);
         longint v;
         v = s;
         return longint'(v * v);
      endfunction

      function longint unsigned add_sat(longint unsigned a, longint unsigned b);
         longint unsigned s;
         s = a + b;
         return (s > SUM_LIMIT) ? longint'(SUM_LIMIT) : s;
      endfunction

      function longint unsigned int_sqrt(longint unsigned x);
         longint unsigned root;
         longint unsigned bit_pos;
         root = 0;
         bit_pos = 64'h1 << 62;
         while (bit_pos > x) bit_pos = bit_pos >> 2;
         while (bit_pos != 0) begin
            if (x >= root + bit_pos) begin
               x = x - (root + bit_pos);
               root = (root >> 1) + bit_pos;
            end else begin
               root = root >> 1;
            end
            bit_pos = bit_pos >> 2;
         end
         return root;
      endfunction

      function longint unsigned smooth_step(longint unsigned old, longint unsigned rms);
         longint unsigned a;
         longint unsigned acc;
         longint unsigned n;
         a = alpha;
         acc = old * (64'd65536 - a) + (rms << 16) * a + 64'd32768;
         n = acc >> 16;
         return (n > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : n;
      endfunction

      function longint unsigned scale_level(longint unsigned sm);
         longint unsigned fs;
         longint unsigned q;
         fs = (full_scale == 0) ? 64'd1 : 64'(full_scale);
         q = sm / (2 * fs);
         return (q > Q16_ONE) ? 64'(Q16_ONE) : q;
      endfunction

      function void note_frame(logic [SAMPLE_BITS-1:0] l, logic [SAMPLE_BITS-1:0] r,
                               logic last);
         longint unsigned rms_l;
         longint unsigned rms_r;
         longint unsigned lvl_l;
         longint unsigned lvl_r;
         level_beat_type  beat;
         sum_left  = add_sat(sum_left, square(l));
         sum_right = add_sat(sum_right, square(r));
         frames++;
         if (!last && frames < FRAMES_MAX) return;
         rms_l = int_sqrt(sum_left / frames);
         rms_r = int_sqrt(sum_right / frames);
         sum_left  = 0;
         sum_right = 0;
         frames    = 0;
         smooth_left  = smooth_step(smooth_left, rms_l);
         smooth_right = smooth_step(smooth_right, rms_r);
         lvl_l = scale_level(smooth_left);
         lvl_r = scale_level(smooth_right);
         beat.gate_trigger = 0;
         if (lvl_l >= threshold && !above) begin
            beat.gate_trigger = 1;
            above = 1;
         end else if (lvl_l < threshold && above) begin
            above = 0;
         end
         beat.level_left  = LEVEL_W'(lvl_l);
         beat.level_right = LEVEL_W'(lvl_r);
         beat.gate_open   = above;
         levels_due = {levels_due, beat};
      endfunction

      function void check_result(level_beat_type got);
         level_beat_type want;
         if (levels_due.size() == 0) begin
            $display("%0t unexpected result: expected none, actual left %0d right %0d %s",
                     $time, got.level_left, got.level_right,
                     $sformatf("trig %0d open %0d", got.gate_trigger, got.gate_open));
            errors++;
            return;
         end
         want = levels_due.pop_front();
         if (got.level_left !== want.level_left) begin
            $display("%0t level_left expected %0d actual %0d", $time, want.level_left,
                     got.level_left);
            errors++;
         end
         if (got.level_right !== want.level_right) begin
            $display("%0t level_right expected %0d actual %0d", $time, want.level_right,
                     got.level_right);
            errors++;
         end
         if (got.gate_trigger !== want.gate_trigger) begin
            $display("%0t gate_trigger expected %0d actual %0d", $time, want.gate_trigger,
                     got.gate_trigger);
            errors++;
         end
         if (got.gate_open !== want.gate_open) begin
            $display("%0t gate_open expected %0d actual %0d", $time, want.gate_open,
                     got.gate_open);
            errors++;
         end
      endfunction

      function int pending();
         return levels_due.size();
      endfunction
   endclass

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_stall;
   logic signed [SAMPLE_BITS-1:0] req_left_sample;
   logic signed [SAMPLE_BITS-1:0] req_right_sample;
   logic                          req_last_frame;
   logic                          rsp_valid;
   logic                          rsp_stall;
   logic [LEVEL_W-1:0]            rsp_level_left;
   logic [LEVEL_W-1:0]            rsp_level_right;
   logic                          rsp_gate_trigger;
   logic                          rsp_gate_open;
   logic                          csr_valid;
   logic                          csr_ready;
   logic [CSR_IDX_W-1:0]          csr_index;
   logic [CSR_DATA_W-1:0]         csr_data;

   level_tracker   levels = new();
   level_beat_type seen;
   int             cycle_count = 0;
   int             burst_left = 0;
   bit             gaps_on = 1;
   stall_mode_type stall_mode = STALL_NONE;
   int             mode_left = 0;
   int             hold_left = 0;

   stereo_rms_level_gate_core #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .FRAMES_MAX (FRAMES_MAX)
   ) u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_left_sample (req_left_sample),
      .req_right_sample(req_right_sample),
      .req_last_frame  (req_last_frame),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_level_left  (rsp_level_left),
      .rsp_level_right (rsp_level_right),
      .rsp_gate_trigger(rsp_gate_trigger),
      .rsp_gate_open   (rsp_gate_open),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   initial clock = 0;
   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         seen.level_left   = rsp_level_left;
         seen.level_right  = rsp_level_right;
         seen.gate_trigger = rsp_gate_trigger;
         seen.gate_open    = rsp_gate_open;
         levels.check_result(seen);
      end
   end

   always @(negedge clock) begin
      if (mode_left == 0) begin
         stall_mode = stall_mode_type'($urandom_range(2, 0));
         mode_left = $urandom_range(300, 50);
      end else begin
         mode_left--;
      end
      case (stall_mode)
         STALL_NONE: begin
            rsp_stall <= 1'b0;
         end
         STALL_SPARSE: begin
            rsp_stall <= ($urandom_range(3, 0) == 0);
         end
         default: begin
            if (hold_left == 0) begin
               rsp_stall <= ~rsp_stall;
               hold_left = $urandom_range(20, 1);
            end else begin
               hold_left--;
            end
         end
      endcase
   end

   function automatic logic [SAMPLE_BITS-1:0] pick_sample(int amp);
      int v;
      if (amp >= 32768) return SAMPLE_BITS'($urandom);
      v = int'($urandom_range(2 * amp, 0)) - amp;
      return SAMPLE_BITS'(v);
   endfunction

   function automatic int pick_amp();
      case ($urandom_range(2, 0))
         0: return $urandom_range(200, 0);
         1: return $urandom_range(6000, 200);
         default: return 32768;
      endcase
   endfunction

   // one request beat per call, valid stays high into the next call
   task automatic send_frame(logic [SAMPLE_BITS-1:0] l, logic [SAMPLE_BITS-1:0] r,
                             logic last);
      @(negedge clock);
      if (gaps_on && burst_left == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(8, 1)) @(negedge clock);
         burst_left = $urandom_range(24, 1);
      end
      req_valid        = 1'b1;
      req_left_sample  = l;
      req_right_sample = r;
      req_last_frame   = last;
      do @(posedge clock); while (req_stall);
      levels.note_frame(l, r, last);
      if (burst_left > 0) burst_left--;
   endtask

   task automatic hold_requests();
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic drain_levels();
      hold_requests();
      while (levels.pending() != 0) @(negedge clock);
   endtask

   task automatic wait_idle();
      drain_levels();
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = data;
      do @(posedge clock); while (!csr_ready);
      levels.write_reg(idx, data);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic set_levels(logic [CSR_DATA_W-1:0] alpha, logic [CSR_DATA_W-1:0] fs,
                             logic [CSR_DATA_W-1:0] thr);
      wait_idle();
      csr_write(CSR_ALPHA, alpha);
      csr_write(CSR_FULL_SCALE, fs);
      csr_write(CSR_THRESHOLD, thr);
      // unmapped index must be ignored
      csr_write(CSR_IDX_W'($urandom_range(255, CSR_THRESHOLD + 1)), CSR_DATA_W'($urandom));
   endtask

   task automatic send_buffer(int len, int amp, bit closed);
      for (int i = 0; i < len; i++) begin
         send_frame(pick_sample(amp), pick_sample(amp), closed && (i == len - 1));
      end
   endtask

   task automatic send_noise(int len);
      for (int i = 0; i < len; i++) begin
         send_frame(SAMPLE_BITS'($urandom), SAMPLE_BITS'($urandom),
                    $urandom_range(3, 0) == 0);
      end
   endtask

   initial begin
      int phase_frames;
      int len;
      int pick;
      bit long_done;
      bit drained;

      reset            = 1'b1;
      req_valid        = 1'b0;
      req_left_sample  = '0;
      req_right_sample = '0;
      req_last_frame   = 1'b0;
      rsp_stall        = 1'b0;
      csr_valid        = 1'b0;
      csr_index        = '0;
      csr_data         = '0;
      long_done        = 0;
      drained          = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // extremes at reset settings
      burst_left = $urandom_range(6, 1);
      send_frame(16'h8000, 16'h8000, 1'b1);
      send_frame(16'h7FFF, 16'h7FFF, 1'b1);
      send_frame(16'h0000, 16'h0000, 1'b1);
      send_frame(16'hFFFF, 16'h0001, 1'b1);
      send_frame(16'h5555, 16'hAAAA, 1'b1);
      send_frame(16'hAAAA, 16'h5555, 1'b1);
      for (int i = 0; i < 4; i++) begin
         send_frame(i[0] ? 16'h7FFF : 16'h8000, i[0] ? 16'h8000 : 16'h7FFF, i == 3);
      end
      // full buffer closes by itself, sums saturate
      for (int i = 0; i < FRAMES_MAX; i++) begin
         send_frame(16'h8000, 16'h8000, 1'b0);
      end

      // gate fires, holds, re-arms, fires
      set_levels(17'd65535, 17'd5571, 17'd32768);
      send_frame(16'h8000, 16'h8000, 1'b1);
      send_frame(16'h7FFF, 16'h0000, 1'b1);
      send_frame(16'h0000, 16'h0000, 1'b1);
      send_frame(16'h8000, 16'h0000, 1'b1);
      // threshold above 1.0 re-arms the open gate, zero full scale
      set_levels(17'd65535, 17'd0, 17'd65537);
      send_frame(16'h7FFF, 16'h7FFF, 1'b1);

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0: set_levels(17'd65535, 17'd5571, 17'd32768);
            1: set_levels(17'd0, 17'd1, 17'd0);
            2: set_levels(CSR_DATA_W'($urandom_range(65535, 0)), 17'd32767, 17'd65536);
            3: set_levels(17'd65535, 17'd0, CSR_DATA_W'($urandom_range(131071, 65537)));
            default: set_levels(CSR_DATA_W'($urandom_range(131071, 0)),
                                CSR_DATA_W'($urandom_range(32767, 1)),
                                CSR_DATA_W'($urandom_range(65536, 0)));
         endcase
         phase_frames = 0;
         while (phase_frames < PHASE_FRAMES) begin
            gaps_on = ($urandom_range(3, 0) != 0);
            pick = $urandom_range(99, 0);
            if (pick < 80) begin
               len = $urandom_range(12, 1);
               send_buffer(len, pick_amp(), 1'b1);
            end else if (pick < 83 && !long_done) begin
               len = $urandom_range(FRAMES_MAX + 40, FRAMES_MAX);
               send_buffer(len, pick_amp(), 1'b0);
               long_done = 1;
            end else begin
               len = $urandom_range(10, 1);
               send_noise(len);
            end
            phase_frames += len;
            if (p == 2 && !drained && phase_frames > PHASE_FRAMES / 2) begin
               drain_levels();
               drained = 1;
            end
         end
         send_frame(pick_sample(pick_amp()), pick_sample(pick_amp()), 1'b1);
      end

      wait_idle();
      if (levels.errors == 0 && levels.pending() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
